>>> hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU table package
// Shared constants, modes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int ENTRIES   = 16;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);
	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int USE_W     = 16;
	localparam int STAMP_W   = 32;
	localparam int NCAP_W    = 16;
	localparam int EVN_W     = 5;
	localparam logic [USE_W-1:0] USE_MAX = '1;

	typedef enum logic [1:0] {
		MODE_GET    = 2'd0,
		MODE_PUT    = 2'd1,
		MODE_RESIZE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_LOOK,
		ST_SCAN,
		ST_EVICT,
		ST_DONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;       // capture input word
		logic search;     // start a scan over slots
		logic scan_step;  // advance scan
		logic evict;      // drop the chosen victim
		logic hit_upd;    // update hit slot
		logic insert;     // insert into free slot
		logic set_cap;    // apply new capacity
		logic publish;    // load output register
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  hit;
		logic  scan_last;
		logic  need_evict;
		logic  cap_zero;
	} sts_t;

endpackage

>>> hdl/lfu_cache_table_core.sv
// ----------------------------------------------------------------------------
// LFU cache table core
// Fully associative key/value table with least-frequently-used replacement.
//
//  channel | signals                                   | dir
//  in      | in_valid, in_ready, mode/key/value/new_cap | sink
//  out     | out_valid, out_ready, hit ... clipped      | source
//
// Get or put hit: load, match, look-up with hit update, then output handoff.
// Put miss on a free slot and resize add a done step (insert or evict check).
// Each eviction adds a serial victim scan over all slots plus an evict step.
// Reset empties the table and sets capacity to ENTRIES; no clearing pass.
// A result waits in the output register; the next word is taken meanwhile.
// ----------------------------------------------------------------------------
module lfu_cache_table_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic signed [lfu_pkg::KEY_W-1:0]  key,
	input  logic signed [lfu_pkg::VAL_W-1:0]  value,
	input  logic [lfu_pkg::NCAP_W-1:0]        new_capacity,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              hit,
	output logic signed [lfu_pkg::VAL_W-1:0]  read_value,
	output logic [lfu_pkg::EVN_W-1:0]         evicted_count,
	output logic signed [lfu_pkg::KEY_W-1:0]  evicted_key,
	output logic                              capacity_clipped
);
	import lfu_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic busy;
	logic out_free;
	logic out_valid_q;

	assign in_ready = !busy;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.publish) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_valid && in_ready),
		.out_free (out_free),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	lfu_dpath u_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.mode               (mode),
		.key                (key),
		.value              (value),
		.new_capacity       (new_capacity),
		.r_hit              (hit),
		.r_read_value       (read_value),
		.r_evicted_count    (evicted_count),
		.r_evicted_key      (evicted_key),
		.r_capacity_clipped (capacity_clipped)
	);

endmodule

>>> hdl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// LFU table controller
// Sequences lookup, victim scan, eviction, update and output handoff.
// ----------------------------------------------------------------------------
module lfu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_free,
	input  lfu_pkg::sts_t sts,
	output logic          busy,
	output lfu_pkg::cmd_t cmd
);
	import lfu_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_nx = ST_MATCH;
				end
			end
			ST_MATCH: begin
				state_nx = ST_LOOK;
			end
			ST_LOOK: begin
				unique case (sts.mode)
					MODE_GET: begin
						if (sts.hit) cmd.hit_upd = 1'b1;
						state_nx = ST_OUT;
					end
					MODE_PUT: begin
						if (sts.hit) begin
							cmd.hit_upd = 1'b1;
							state_nx = ST_OUT;
						end else if (sts.cap_zero) begin
							state_nx = ST_OUT;
						end else begin
							state_nx = ST_DONE;
						end
					end
					MODE_RESIZE: begin
						cmd.set_cap = 1'b1;
						state_nx = ST_DONE;
					end
					default: state_nx = ST_OUT;
				endcase
			end
			ST_DONE: begin
				if (sts.need_evict) begin
					cmd.search = 1'b1;
					state_nx = ST_SCAN;
				end else begin
					if (sts.mode == MODE_PUT) cmd.insert = 1'b1;
					state_nx = ST_OUT;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_nx = ST_EVICT;
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_nx = ST_DONE;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

>>> hdl/lfu_dpath.sv
// ----------------------------------------------------------------------------
// LFU table datapath
// Slot registers, parallel key match, serial victim scan and result build.
// ----------------------------------------------------------------------------
module lfu_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lfu_pkg::cmd_t                   cmd,
	output lfu_pkg::sts_t                   sts,
	input  logic [1:0]                      mode,
	input  logic signed [lfu_pkg::KEY_W-1:0]  key,
	input  logic signed [lfu_pkg::VAL_W-1:0]  value,
	input  logic [lfu_pkg::NCAP_W-1:0]      new_capacity,
	output logic                            r_hit,
	output logic signed [lfu_pkg::VAL_W-1:0]  r_read_value,
	output logic [lfu_pkg::EVN_W-1:0]       r_evicted_count,
	output logic signed [lfu_pkg::KEY_W-1:0]  r_evicted_key,
	output logic                            r_capacity_clipped
);
	import lfu_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q [ENTRIES];
	logic [VAL_W-1:0]   val_q [ENTRIES];
	logic [USE_W-1:0]   use_q [ENTRIES];
	logic [STAMP_W-1:0] stamp_q [ENTRIES];
	logic [CNT_W-1:0]   cap_q;
	logic [CNT_W-1:0]   occ_q;
	logic [STAMP_W-1:0] seq_q;

	mode_t              mode_q;
	logic [KEY_W-1:0]   in_key_q;
	logic [VAL_W-1:0]   in_val_q;
	logic [NCAP_W-1:0]  ncap_q;

	logic [ENTRIES-1:0] match_q;
	logic               hit_q;
	logic [VAL_W-1:0]   rd_q;
	logic [EVN_W-1:0]   evn_q;
	logic [KEY_W-1:0]   evk_q;
	logic               clip_q;

	logic [IDX_W-1:0]   scan_q;
	logic               best_ok_q;
	logic [IDX_W-1:0]   best_q;
	logic [USE_W-1:0]   best_cnt_q;
	logic [STAMP_W-1:0] best_age_q;

	logic [ENTRIES-1:0] match_c;
	logic               hit_c;
	logic [IDX_W-1:0]   hit_idx_c;
	logic [IDX_W-1:0]   free_idx_c;
	logic [STAMP_W-1:0] age_c;
	logic               better_c;
	logic [CNT_W-1:0]   ncap_clip_c;
	logic               clip_c;

	always_comb begin
		match_c = '0;
		for (int i = 0; i < ENTRIES; i++)
			match_c[i] = valid_q[i] && (key_q[i] == in_key_q);
	end

	always_comb begin
		hit_c = 1'b0;
		hit_idx_c = '0;
		free_idx_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_c = 1'b1;
				hit_idx_c = IDX_W'(i);
			end
			if (!valid_q[i]) free_idx_c = IDX_W'(i);
		end
	end

	assign age_c = seq_q - stamp_q[scan_q];
	assign better_c = valid_q[scan_q] && (!best_ok_q || use_q[scan_q] < best_cnt_q ||
		(use_q[scan_q] == best_cnt_q && age_c > best_age_q));

	assign clip_c = (ncap_q > NCAP_W'(ENTRIES));
	assign ncap_clip_c = clip_c ? CNT_W'(ENTRIES) : CNT_W'(ncap_q);

	assign sts.mode = mode_q;
	assign sts.hit = hit_c;
	assign sts.scan_last = (scan_q == IDX_W'(ENTRIES - 1));
	assign sts.cap_zero = (cap_q == '0);
	assign sts.need_evict = (mode_q == MODE_PUT) ? (occ_q >= cap_q) : (occ_q > cap_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cap_q <= CNT_W'(ENTRIES);
			occ_q <= '0;
			seq_q <= '0;
		end else begin
			if (cmd.set_cap) cap_q <= ncap_clip_c;
			if (cmd.hit_upd) seq_q <= seq_q + 1'b1;
			if (cmd.insert) begin
				valid_q[free_idx_c] <= 1'b1;
				occ_q <= occ_q + 1'b1;
				seq_q <= seq_q + 1'b1;
			end
			if (cmd.evict) begin
				valid_q[best_q] <= 1'b0;
				occ_q <= occ_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			in_key_q <= key;
			in_val_q <= value;
			ncap_q <= new_capacity;
			evn_q <= '0;
			evk_q <= '0;
			clip_q <= 1'b0;
			rd_q <= (mode_t'(mode) == MODE_GET) ? '1 : '0;
			hit_q <= 1'b0;
		end
		if (cmd.load) match_q <= '0;
		else match_q <= match_c;
		if (cmd.hit_upd) begin
			hit_q <= 1'b1;
			if (mode_q == MODE_GET) rd_q <= val_q[hit_idx_c];
			else val_q[hit_idx_c] <= in_val_q;
			if (use_q[hit_idx_c] != USE_MAX) use_q[hit_idx_c] <= use_q[hit_idx_c] + 1'b1;
			stamp_q[hit_idx_c] <= seq_q;
		end
		if (cmd.set_cap) clip_q <= clip_c;
		if (cmd.insert) begin
			key_q[free_idx_c] <= in_key_q;
			val_q[free_idx_c] <= in_val_q;
			use_q[free_idx_c] <= USE_W'(1);
			stamp_q[free_idx_c] <= seq_q;
		end
		if (cmd.search) begin
			scan_q <= '0;
			best_ok_q <= 1'b0;
		end
		if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (better_c) begin
				best_ok_q <= 1'b1;
				best_q <= scan_q;
				best_cnt_q <= use_q[scan_q];
				best_age_q <= age_c;
			end
		end
		if (cmd.evict) begin
			evn_q <= evn_q + 1'b1;
			evk_q <= key_q[best_q];
		end
		if (cmd.publish) begin
			r_hit <= hit_q && (mode_q == MODE_GET || mode_q == MODE_PUT);
			r_read_value <= rd_q;
			r_evicted_count <= evn_q;
			r_evicted_key <= evk_q;
			r_capacity_clipped <= clip_q;
		end
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LFU cache table core testbench
// Drives get/put/resize words through the valid/ready input, predicts each
// result with a behavioral LFU table (count, then age, then slot order), and
// checks every output word in order under random idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
	import lfu_pkg::*;

	typedef struct packed {
		logic [1:0]        mode;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [NCAP_W-1:0] ncap;
	} cmd_word_t;

	typedef struct packed {
		logic              hit;
		logic [VAL_W-1:0]  rd;
		logic [EVN_W-1:0]  ev_n;
		logic [KEY_W-1:0]  ev_key;
		logic              clipped;
	} res_word_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [1:0] mode;
	logic signed [KEY_W-1:0] key;
	logic signed [VAL_W-1:0] value;
	logic [NCAP_W-1:0] new_capacity;
	logic hit, capacity_clipped;
	logic signed [VAL_W-1:0] read_value;
	logic [EVN_W-1:0] evicted_count;
	logic signed [KEY_W-1:0] evicted_key;

	lfu_cache_table_core dut (.*);

	// table copy kept by the predictor
	logic             tv [ENTRIES];
	logic [KEY_W-1:0] tk [ENTRIES];
	logic [VAL_W-1:0] tval [ENTRIES];
	logic [USE_W-1:0] tuse [ENTRIES];
	logic [31:0]      tstamp [ENTRIES];
	int unsigned      tcap;
	logic [31:0]      tseq;

	cmd_word_t pending_words[$];
	res_word_t expected_results[$];
	int   errors = 0, cycles = 0, n_results = 0, n_evicts = 0, n_hits = 0;
	int   send_idle = 27, recv_idle = 51;
	bit   pause_send = 0, stim_done = 0;
	int   hold_left = 0;

	function automatic int lfu_victim();
		int best;
		logic [31:0] age, best_age;
		best = -1;
		best_age = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (!tv[i]) continue;
			age = tseq - tstamp[i];
			if (best < 0 || tuse[i] < tuse[best] ||
			    (tuse[i] == tuse[best] && age > best_age)) begin
				best = i;
				best_age = age;
			end
		end
		return best;
	endfunction

	function automatic int occupancy();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++) n += tv[i];
		return n;
	endfunction

	function automatic void refresh_slot(int i);
		if (tuse[i] != USE_MAX) tuse[i]++;
		tstamp[i] = tseq;
		tseq++;
	endfunction

	function automatic res_word_t lfu_predict(cmd_word_t c);
		res_word_t r;
		int s, v;
		r = '0;
		s = -1;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (tv[i] && tk[i] == c.key) s = i;
		case (c.mode)
		MODE_GET: begin
			if (s >= 0) begin
				r.hit = 1;
				r.rd = tval[s];
				refresh_slot(s);
			end else
				r.rd = '1;
		end
		MODE_PUT: begin
			if (s >= 0) begin
				r.hit = 1;
				tval[s] = c.value;
				refresh_slot(s);
			end else if (tcap != 0) begin
				while (occupancy() >= tcap) begin
					v = lfu_victim();
					if (v < 0) break;
					tv[v] = 0;
					r.ev_n++;
					r.ev_key = tk[v];
				end
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!tv[i]) s = i;
				if (s >= 0) begin
					tv[s] = 1;
					tk[s] = c.key;
					tval[s] = c.value;
					tuse[s] = 1;
					tstamp[s] = tseq;
					tseq++;
				end
			end
		end
		MODE_RESIZE: begin
			tcap = c.ncap;
			if (c.ncap > ENTRIES) begin
				tcap = ENTRIES;
				r.clipped = 1;
			end
			while (occupancy() > tcap) begin
				v = lfu_victim();
				if (v < 0) break;
				tv[v] = 0;
				r.ev_n++;
				r.ev_key = tk[v];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic void add_word(logic [1:0] m, logic [31:0] k, logic [31:0] d,
	                                 int unsigned nc);
		cmd_word_t c;
		c.mode = m;
		c.key = k;
		c.value = d;
		c.ncap = NCAP_W'(nc);
		pending_words.push_back(c);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		cmd_word_t c;
		if (!arst_n) begin
			in_valid <= 0;
			mode <= '0;
			key <= '0;
			value <= '0;
			new_capacity <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) expected_results.push_back(lfu_predict({mode, key, value,
				new_capacity}));
			if (pending_words.size() != 0 && !pause_send &&
			    $urandom_range(99) >= send_idle) begin
				c = pending_words.pop_front();
				in_valid <= 1;
				mode <= c.mode;
				key <= c.key;
				value <= c.value;
				new_capacity <= c.ncap;
			end else
				in_valid <= 0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		res_word_t e;
		if (!arst_n)
			out_ready <= 0;
		else begin
			cycles++;
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_results.size() == 0) begin
					$error("unexpected result word");
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (hit !== e.hit) begin
						$error("hit exp %0d got %0d", e.hit, hit); errors++;
					end
					if (read_value !== e.rd) begin
						$error("read_value exp %0h got %0h", e.rd, read_value); errors++;
					end
					if (evicted_count !== e.ev_n) begin
						$error("evicted_count exp %0d got %0d", e.ev_n, evicted_count);
						errors++;
					end
					if (evicted_key !== e.ev_key) begin
						$error("evicted_key exp %0h got %0h", e.ev_key, evicted_key);
						errors++;
					end
					if (capacity_clipped !== e.clipped) begin
						$error("capacity_clipped exp %0d got %0d", e.clipped,
							capacity_clipped);
						errors++;
					end
					n_hits += e.hit;
					n_evicts += e.ev_n;
				end
			end
			if (hold_left > 0) hold_left--;
			out_ready <= !(hold_left > 0) && $urandom_range(99) >= recv_idle;
		end
	end

	initial begin
		int bank;
		logic [31:0] k;
		logic [1:0] m;
		for (int i = 0; i < ENTRIES; i++) begin
			tv[i] = 0; tk[i] = 0; tval[i] = 0; tuse[i] = 0; tstamp[i] = 0;
		end
		tcap = ENTRIES;
		tseq = 0;
		arst_n = 0;
		// directed: extremes, all modes, clip, zero capacity, tie/age eviction
		add_word(MODE_GET, 32'h8000_0000, 0, 0);
		add_word(MODE_PUT, 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
		add_word(MODE_PUT, 32'h7fff_ffff, 32'h8000_0000, 0);
		add_word(MODE_PUT, 32'hffff_ffff, 32'hffff_ffff, 0);
		add_word(MODE_GET, 32'h8000_0000, 0, 0);
		add_word(MODE_PUT, 32'h7fff_ffff, 32'h1234_5678, 0);
		add_word(MODE_NONE, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
		add_word(MODE_RESIZE, 0, 0, 16'h0002);
		add_word(MODE_PUT, 32'h0, 32'h0, 0);
		add_word(MODE_RESIZE, 0, 0, 16'h0000);
		add_word(MODE_PUT, 32'h5, 32'h5, 0);
		add_word(MODE_GET, 32'h5, 0, 0);
		add_word(MODE_RESIZE, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
		add_word(MODE_RESIZE, 0, 0, 16'd17);
		for (int i = 0; i < 18; i++) add_word(MODE_PUT, i, ~i, 0);
		add_word(MODE_RESIZE, 0, 0, 16'd16);
		repeat (2) @(posedge clk);
		arst_n <= 1;
		wait (pending_words.size() == 0);
		// random phases under three idling patterns
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin send_idle = 51; recv_idle = 27; end
			if (ph == 2) begin send_idle = 0; recv_idle = 0; end
			for (int n = 0; n < 400; n++) begin
				bank = $urandom_range(99);
				k = (bank < 85) ? $urandom_range(23) : $urandom;
				m = (bank % 10 < 4) ? MODE_GET : MODE_PUT;
				if ($urandom_range(99) < 4) m = MODE_RESIZE;
				if ($urandom_range(199) == 0) m = MODE_NONE;
				add_word(m, k, $urandom,
					($urandom_range(9) == 0) ? $urandom : $urandom_range(16));
			end
			if (ph == 0) begin
				hold_left = 300;
				wait (hold_left == 0);
			end
			wait (pending_words.size() == 0);
			pause_send = 1;
			wait (expected_results.size() == 0 && !in_valid);
			pause_send = 0;
		end
		add_word(MODE_RESIZE, 0, 0, 16'd16);
		add_word(MODE_PUT, 32'h4242, 1, 0);
		add_word(MODE_PUT, 32'h4243, 2, 0);
		add_word(MODE_RESIZE, 0, 0, 16'd1);
		wait (pending_words.size() == 0);
		stim_done = 1;
	end

	initial begin
		wait (stim_done && !in_valid && expected_results.size() == 0);
		repeat (ENTRIES * (ENTRIES + 2) + 20) @(posedge clk);
		$display("covered %0d result words, %0d hits, %0d evictions", n_results, n_hits,
			n_evicts);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		wait (cycles >= 3000000);
		$display("timeout after %0d cycles", cycles);
		$display("testbench: FAIL");
		$finish;
	end
endmodule
